/* src/stbs_pkg.sv */
// Shared types and constants for the swept-tone blip synthesizer.
package stbs_pkg;

	typedef struct packed {
		logic       command;
		logic [5:0] blip_index;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               in_tone;
		logic               last_of_slot;
	} out_word_t;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	localparam logic [2:0] REG_TONE_LEN     = 3'd0;
	localparam logic [2:0] REG_GAP_LEN      = 3'd1;
	localparam logic [2:0] REG_ATTACK_LEN   = 3'd2;
	localparam logic [2:0] REG_TAIL_LEN     = 3'd3;
	localparam logic [2:0] REG_BASE_STEP    = 3'd4;
	localparam logic [2:0] REG_STEP_RATIO   = 3'd5;
	localparam logic [2:0] REG_SWEEP_RATIO  = 3'd6;
	localparam logic [2:0] REG_DECAY_FACTOR = 3'd7;

	localparam logic [47:0] STEP_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [23:0] Q23_ONE  = 24'h80_0000;
	localparam logic [30:0] Q30_ONE  = 31'h4000_0000;

	localparam logic [31:0] SIN_C0 = 32'd172272;
	localparam logic [31:0] SIN_C1 = 32'd5026996;
	localparam logic [31:0] SIN_C2 = 32'd85569306;
	localparam logic [31:0] SIN_C3 = 32'd693598669;
	localparam logic [31:0] SIN_C4 = 32'd1686629713;

endpackage

/* src/stbs_mul.sv */
// Shared sequential multiplier: 48 by 40 bits, one 24-bit slice per cycle.
module stbs_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] a,
	input  logic [39:0] b,
	output logic        done,
	output logic [87:0] product
);
	logic [1:0]  cnt_q;
	logic        busy_q;
	logic [47:0] a_q;
	logic [39:0] b_q;
	logic [87:0] acc_q;
	logic [23:0] slice;
	logic [63:0] part;

	assign slice = cnt_q[0] ? a_q[47:24] : a_q[23:0];
	assign part  = {40'd0, slice} * {24'd0, b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 2'd0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q[0]) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q[0]) acc_q <= acc_q + {part, 24'd0};
			else          acc_q <= acc_q + {24'd0, part};
		end
	end

	assign product = acc_q;
endmodule

/* src/stbs_div.sv */
// Shared restoring divider: 40-bit dividend by 16-bit divisor, one bit per cycle.
module stbs_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [39:0] dividend,
	input  logic [15:0] divisor,
	output logic        done,
	output logic [39:0] quotient
);
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [39:0] quo_q;
	logic [16:0] rem_q;
	logic [15:0] dvs_q;
	logic [16:0] trial;
	logic [17:0] diff;

	assign trial = {rem_q[15:0], quo_q[39]};
	assign diff  = {1'b0, trial} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 6'd0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd39) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[17]) begin
				rem_q <= diff[16:0];
				quo_q <= {quo_q[38:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[38:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
endmodule

/* src/swept_tone_blip_synth.sv */
// Top level: register file, sequencer and state of the swept-tone blip synthesizer.
// A start word multiplies the phase step by the step ratio once for each blip index step.
// A tone tick gives its result after up to two divisions in the shared divider and
// passes through the one shared multiplier; a gap tick skips them and goes to ST_FIN.
// One word is worked at a time; the result waits in an output register.
// Asynchronous active-low reset restores the register defaults and goes idle.
module swept_tone_blip_synth #(
	parameter int BLIP_COUNT       = 8,
	parameter int PEAK_AMPLITUDE   = 30000,
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  stbs_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output stbs_pkg::out_word_t out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [5:0]          paddr,
	input  logic [63:0]         pwdata,
	output logic [63:0]         prdata,
	output logic                pready
);
	localparam int TBITS = $clog2(SINE_TABLE_DEPTH);

	localparam logic [4:0] ST_IDLE   = 5'd0;
	localparam logic [4:0] ST_PWR    = 5'd1;
	localparam logic [4:0] ST_PWRW   = 5'd2;
	localparam logic [4:0] ST_TICK   = 5'd3;
	localparam logic [4:0] ST_ATKW   = 5'd4;
	localparam logic [4:0] ST_DECW   = 5'd5;
	localparam logic [4:0] ST_TAILM  = 5'd6;
	localparam logic [4:0] ST_TAILMW = 5'd7;
	localparam logic [4:0] ST_TAILDW = 5'd8;
	localparam logic [4:0] ST_SIN0   = 5'd9;
	localparam logic [4:0] ST_SQW    = 5'd10;
	localparam logic [4:0] ST_HORN   = 5'd11;
	localparam logic [4:0] ST_HORNW  = 5'd12;
	localparam logic [4:0] ST_LASTW  = 5'd13;
	localparam logic [4:0] ST_ENVW   = 5'd14;
	localparam logic [4:0] ST_PEAKW  = 5'd15;
	localparam logic [4:0] ST_SWPW   = 5'd16;
	localparam logic [4:0] ST_FIN    = 5'd17;

	logic [4:0]  state_q;
	logic [15:0] tone_len_q, gap_len_q, attack_len_q, tail_len_q;
	logic [30:0] base_step_q;
	logic [31:0] step_ratio_q;
	logic [39:0] sweep_ratio_q;
	logic [23:0] decay_factor_q;

	logic [31:0] phase_acc_q;
	logic [47:0] phase_step_q;
	logic [16:0] sample_count_q;
	logic [23:0] decay_level_q;
	logic        playing_q;

	logic [5:0]  idx_left_q;
	logic [23:0] env_q;
	logic [30:0] t_q, t2_q;
	logic [31:0] poly_q;
	logic [2:0]  horn_q;
	logic        neg_q;
	logic [40:0] mag_q;

	logic        mul_start, mul_done, div_start, div_done;
	logic [47:0] mul_a;
	logic [39:0] mul_b;
	logic [87:0] mul_p;
	logic [39:0] div_n, div_q;
	logic [15:0] div_d;

	logic        out_valid_q;
	stbs_pkg::out_word_t out_q;

	logic        cfg_wr;
	logic [2:0]  cfg_idx;
	logic [17:0] n_ext, slot;
	logic [31:0] u_addr;
	logic [29:0] r_frac;
	logic [30:0] t_cur;
	logic [47:0] sat_step30, sat_step38;
	logic [31:0] poly_coef;
	logic [31:0] horn_sub;

	stbs_mul u_mul (.clk, .arst_n, .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .product(mul_p));
	stbs_div u_div (.clk, .arst_n, .start(div_start), .dividend(div_n), .divisor(div_d),
		.done(div_done), .quotient(div_q));

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[5:3];

	always_comb begin
		unique case (cfg_idx)
			stbs_pkg::REG_TONE_LEN:     prdata = {48'd0, tone_len_q};
			stbs_pkg::REG_GAP_LEN:      prdata = {48'd0, gap_len_q};
			stbs_pkg::REG_ATTACK_LEN:   prdata = {48'd0, attack_len_q};
			stbs_pkg::REG_TAIL_LEN:     prdata = {48'd0, tail_len_q};
			stbs_pkg::REG_BASE_STEP:    prdata = {33'd0, base_step_q};
			stbs_pkg::REG_STEP_RATIO:   prdata = {32'd0, step_ratio_q};
			stbs_pkg::REG_SWEEP_RATIO:  prdata = {24'd0, sweep_ratio_q};
			default:                    prdata = {40'd0, decay_factor_q};
		endcase
	end

	assign n_ext  = {1'b0, sample_count_q};
	assign slot   = {2'b00, tone_len_q} + {2'b00, gap_len_q};
	assign u_addr = {phase_acc_q[31 -: TBITS], {(32 - TBITS){1'b0}}};
	assign r_frac = u_addr[29:0];
	assign t_cur  = u_addr[30] ? (stbs_pkg::Q30_ONE - {1'b0, r_frac}) : {1'b0, r_frac};

	assign sat_step30 = (mul_p[87:78] != '0) ? stbs_pkg::STEP_MAX :
		(mul_p[77] ? stbs_pkg::STEP_MAX : mul_p[77:30]);
	assign sat_step38 = (mul_p[87:86] != '0) ? stbs_pkg::STEP_MAX :
		(mul_p[85] ? stbs_pkg::STEP_MAX : mul_p[85:38]);

	always_comb begin
		unique case (horn_q)
			3'd0:    poly_coef = stbs_pkg::SIN_C1;
			3'd1:    poly_coef = stbs_pkg::SIN_C2;
			3'd2:    poly_coef = stbs_pkg::SIN_C3;
			default: poly_coef = stbs_pkg::SIN_C4;
		endcase
	end
	assign horn_sub = poly_coef - mul_p[61:30];

	always_comb begin
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_n     = '0;
		div_d     = tail_len_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready && in_data.command == stbs_pkg::CMD_TICK && playing_q
					&& n_ext < {2'b00, tone_len_q}) begin
					if (n_ext < {2'b00, attack_len_q}) begin
						div_start = 1'b1;
						div_n     = {sample_count_q, 23'd0};
						div_d     = attack_len_q;
					end else begin
						mul_start = 1'b1;
						mul_a     = {24'd0, decay_level_q};
						mul_b     = {16'd0, decay_factor_q};
					end
				end
			end
			ST_PWR: begin
				mul_start = 1'b1;
				mul_a     = phase_step_q;
				mul_b     = {8'd0, step_ratio_q};
			end
			ST_TAILM: begin
				mul_start = 1'b1;
				mul_a     = {24'd0, env_q};
				mul_b     = {24'd0, tone_len_q} - {23'd0, sample_count_q};
			end
			ST_TAILMW: begin
				if (mul_done) begin
					div_start = 1'b1;
					div_n     = mul_p[39:0];
				end
			end
			ST_SIN0: begin
				mul_start = 1'b1;
				mul_a     = {17'd0, t_cur};
				mul_b     = {9'd0, t_cur};
			end
			ST_HORN: begin
				mul_start = 1'b1;
				mul_a     = {16'd0, poly_q};
				mul_b     = {9'd0, (horn_q == 3'd4) ? t_q : t2_q};
			end
			ST_LASTW: begin
				if (mul_done) begin
					mul_start = 1'b1;
					mul_a     = {17'd0, (mul_p[61:30] > {1'b0, stbs_pkg::Q30_ONE}) ?
						stbs_pkg::Q30_ONE : mul_p[60:30]};
					mul_b     = {16'd0, env_q};
				end
			end
			ST_ENVW: begin
				if (mul_done) begin
					mul_start = 1'b1;
					mul_a     = {7'd0, mul_p[63:23]};
					mul_b     = 40'(PEAK_AMPLITUDE);
				end
			end
			ST_PEAKW: begin
				if (mul_done) begin
					mul_start = 1'b1;
					mul_a     = phase_step_q;
					mul_b     = sweep_ratio_q;
				end
			end
			default: ;
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			tone_len_q     <= 16'd4800;
			gap_len_q      <= 16'd2400;
			attack_len_q   <= 16'd48;
			tail_len_q     <= 16'd240;
			base_step_q    <= 31'd39370534;
			step_ratio_q   <= 32'd1073741824;
			sweep_ratio_q  <= 40'd274877906944;
			decay_factor_q <= 24'd8388608;
			phase_acc_q    <= '0;
			phase_step_q   <= '0;
			sample_count_q <= '0;
			decay_level_q  <= stbs_pkg::Q23_ONE;
			playing_q      <= 1'b0;
			out_valid_q    <= 1'b0;
			out_q          <= '0;
			idx_left_q     <= '0;
			horn_q         <= '0;
			env_q          <= '0;
			t_q            <= '0;
			t2_q           <= '0;
			poly_q         <= '0;
			neg_q          <= 1'b0;
			mag_q          <= '0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (cfg_wr) begin
				unique case (cfg_idx)
					stbs_pkg::REG_TONE_LEN:    tone_len_q     <= pwdata[15:0];
					stbs_pkg::REG_GAP_LEN:     gap_len_q      <= pwdata[15:0];
					stbs_pkg::REG_ATTACK_LEN:  attack_len_q   <= pwdata[15:0];
					stbs_pkg::REG_TAIL_LEN:    tail_len_q     <= pwdata[15:0];
					stbs_pkg::REG_BASE_STEP:   base_step_q    <= pwdata[30:0];
					stbs_pkg::REG_STEP_RATIO:  step_ratio_q   <= pwdata[31:0];
					stbs_pkg::REG_SWEEP_RATIO: sweep_ratio_q  <= pwdata[39:0];
					default:                   decay_factor_q <= pwdata[23:0];
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						if (in_data.command == stbs_pkg::CMD_START) begin
							if (32'(in_data.blip_index) < 32'(BLIP_COUNT)) begin
								phase_step_q   <= {1'b0, base_step_q, 16'd0};
								phase_acc_q    <= '0;
								sample_count_q <= '0;
								decay_level_q  <= stbs_pkg::Q23_ONE;
								playing_q      <= 1'b1;
								idx_left_q     <= in_data.blip_index;
								if (in_data.blip_index != '0) state_q <= ST_PWR;
							end
						end else if (!playing_q) begin
							out_q       <= '0;
							out_valid_q <= 1'b1;
						end else if (n_ext < {2'b00, tone_len_q}) begin
							if (n_ext < {2'b00, attack_len_q}) state_q <= ST_ATKW;
							else state_q <= ST_DECW;
						end else begin
							state_q <= ST_FIN;
							neg_q   <= 1'b0;
							mag_q   <= '0;
						end
					end
				end
				ST_PWR: state_q <= ST_PWRW;
				ST_PWRW: begin
					if (mul_done) begin
						phase_step_q <= sat_step30;
						idx_left_q   <= idx_left_q - 6'd1;
						state_q      <= (idx_left_q == 6'd1) ? ST_IDLE : ST_PWR;
					end
				end
				ST_ATKW: begin
					if (div_done) begin
						env_q   <= div_q[23:0];
						state_q <= ST_TICK;
					end
				end
				ST_DECW: begin
					if (mul_done) begin
						env_q         <= decay_level_q;
						decay_level_q <= (mul_p[47:47] != '0) ? 24'hFF_FFFF : mul_p[46:23];
						state_q       <= ST_TICK;
					end
				end
				ST_TICK: begin
					if (n_ext + {2'b00, tail_len_q} >= {2'b00, tone_len_q}) state_q <= ST_TAILM;
					else state_q <= ST_SIN0;
				end
				ST_TAILM:  state_q <= ST_TAILMW;
				ST_TAILMW: if (mul_done) state_q <= ST_TAILDW;
				ST_TAILDW: begin
					if (div_done) begin
						env_q   <= div_q[23:0];
						state_q <= ST_SIN0;
					end
				end
				ST_SIN0: begin
					t_q     <= t_cur;
					neg_q   <= u_addr[31];
					state_q <= ST_SQW;
				end
				ST_SQW: begin
					if (mul_done) begin
						t2_q    <= mul_p[60:30];
						poly_q  <= stbs_pkg::SIN_C0;
						horn_q  <= 3'd0;
						state_q <= ST_HORN;
					end
				end
				ST_HORN: state_q <= (horn_q == 3'd4) ? ST_LASTW : ST_HORNW;
				ST_HORNW: begin
					if (mul_done) begin
						poly_q  <= horn_sub;
						horn_q  <= horn_q + 3'd1;
						state_q <= ST_HORN;
					end
				end
				ST_LASTW: if (mul_done) state_q <= ST_ENVW;
				ST_ENVW:  if (mul_done) state_q <= ST_PEAKW;
				ST_PEAKW: begin
					if (mul_done) begin
						mag_q   <= mul_p[70:30];
						state_q <= ST_SWPW;
					end
				end
				ST_SWPW: begin
					if (mul_done) begin
						phase_step_q <= sat_step38;
						phase_acc_q  <= phase_acc_q + phase_step_q[47:16];
						state_q      <= ST_FIN;
					end
				end
				ST_FIN: begin
					out_q.in_tone      <= n_ext < {2'b00, tone_len_q};
					out_q.last_of_slot <= (n_ext + 18'd1 >= slot);
					if (mag_q > 41'd32767)
						out_q.sample <= neg_q ? -16'sd32767 : 16'sd32767;
					else
						out_q.sample <= neg_q ? -$signed({1'b0, mag_q[14:0]}) :
							$signed({1'b0, mag_q[14:0]});
					if (n_ext + 18'd1 >= slot) playing_q <= 1'b0;
					sample_count_q <= sample_count_q + 17'd1;
					out_valid_q    <= 1'b1;
					state_q        <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
